### rtl/sorted_key_array_engine_unit_defines.svh
// Assertion helpers shared by the RTL files that check themselves.
// Each macro clocks on clk and is quiet while rst_n is low.
`ifndef SORTED_KEY_ARRAY_ENGINE_UNIT_DEFINES_SVH
`define SORTED_KEY_ARRAY_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SKAE_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication.
`define SKAE_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### rtl/skae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skae_pkg;

    // Default geometry
    localparam int SKAE_DEPTH     = 16;
    localparam int SKAE_KEY_WIDTH = 32;

    // Index and count widths carried on the cell control bus (covers depth up to 256)
    localparam int CTL_IDX_W = 8;
    localparam int CTL_CNT_W = 9;

    // Opcodes
    localparam logic [3:0] OP_INSERT      = 4'd0;
    localparam logic [3:0] OP_REMOVE      = 4'd1;
    localparam logic [3:0] OP_REPLACE     = 4'd2;
    localparam logic [3:0] OP_SWAP        = 4'd3;
    localparam logic [3:0] OP_FIND_SEQ    = 4'd4;
    localparam logic [3:0] OP_FIND_SORTED = 4'd5;
    localparam logic [3:0] OP_SORT        = 4'd6;
    localparam logic [3:0] OP_UNIQ_ADJ    = 4'd7;
    localparam logic [3:0] OP_UNIQ_SORTED = 4'd8;
    localparam logic [3:0] OP_CLEAR       = 4'd9;
    localparam logic [3:0] OP_READ        = 4'd10;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Command item
    typedef struct packed {
        logic [3:0]  opcode;
        logic [4:0]  position;
        logic [3:0]  other_position;
        logic [31:0] key_value;
    } cmd_item_t;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [3:0]  found_index;
        logic [31:0] read_value;
        logic [4:0]  count;
        logic        is_ordered;
    } rsp_item_t;

    // What every cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,   // keep, or take a targeted write
        CELL_SHR  = 2'd1,   // open a gap at pos, shifting toward the end
        CELL_SHL  = 2'd2,   // close the slot at pos, shifting toward the front
        CELL_SORT = 2'd3    // one odd-even compare-exchange phase
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [CTL_IDX_W-1:0]   pos;
        logic [CTL_IDX_W-1:0]   a_idx;
        logic [CTL_IDX_W-1:0]   b_idx;
        logic                   wr_a;
        logic                   wr_b;
        logic                   parity;
        logic [CTL_CNT_W-1:0]   count;
    } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/skae_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the key chain. Holds a key and trades it with its neighbors.
module skae_cell #(
    parameter int KEY_WIDTH = skae_pkg::SKAE_KEY_WIDTH,
    parameter int INDEX     = 0
) (
    input  logic                  clk,
    input  skae_pkg::cell_ctl_t   ctl,
    input  logic [KEY_WIDTH-1:0]  data_a,
    input  logic [KEY_WIDTH-1:0]  data_b,
    input  logic [KEY_WIDTH-1:0]  cmp_key,
    input  logic [KEY_WIDTH-1:0]  left_key,
    input  logic [KEY_WIDTH-1:0]  right_key,
    output logic [KEY_WIDTH-1:0]  key_q,
    output logic                  eq_key,
    output logic                  ge_key,
    output logic                  le_key,
    output logic                  eq_left
);
    import skae_pkg::*;

    localparam logic [CTL_IDX_W-1:0] MY_IDX   = CTL_IDX_W'(INDEX);
    localparam logic [CTL_CNT_W-1:0] NEXT_NUM = CTL_CNT_W'(INDEX + 1);
    localparam logic [CTL_CNT_W-1:0] MY_NUM   = CTL_CNT_W'(INDEX);
    localparam logic                 HAS_LEFT = (INDEX > 0);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 pair_left;
    logic                 pair_right;

    // Pair membership in the current sort phase
    assign pair_left  = (MY_IDX[0] == ctl.parity) && (NEXT_NUM < ctl.count);
    assign pair_right = HAS_LEFT && (MY_IDX[0] != ctl.parity) && (MY_NUM < ctl.count);

    // Next key
    always_comb
    begin
        key_next = key_reg;
        unique case (ctl.op)
            CELL_HOLD:
            begin
                if (ctl.wr_a && (ctl.a_idx == MY_IDX))
                    key_next = data_a;
                else if (ctl.wr_b && (ctl.b_idx == MY_IDX))
                    key_next = data_b;
            end
            CELL_SHR:
            begin
                if (MY_IDX > ctl.pos)
                    key_next = left_key;
                else if (MY_IDX == ctl.pos)
                    key_next = data_a;
            end
            CELL_SHL:
            begin
                if (MY_IDX >= ctl.pos)
                    key_next = right_key;
            end
            CELL_SORT:
            begin
                if (pair_left && (key_reg > right_key))
                    key_next = right_key;
                else if (pair_right && (left_key > key_reg))
                    key_next = left_key;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    // Local compares against the search key and the left neighbor
    assign key_q   = key_reg;
    assign eq_key  = (cmp_key == key_reg);
    assign ge_key  = (cmp_key >= key_reg);
    assign le_key  = (cmp_key <= key_reg);
    assign eq_left = (key_reg == left_key);

endmodule

`default_nettype wire

### rtl/sorted_key_array_engine_unit.sv
// Channel  | Handshake             | Payload     | Direction
// ---------+-----------------------+-------------+----------
// cmd      | cmd_valid / cmd_stall | cmd_item    | in
// rsp      | rsp_valid / rsp_stall | rsp_item    | out
// cfg      | cfg_valid / cfg_ready | cfg_data    | in
//
// One item at a time. Insert, remove, replace, read, clear and unused codes finish
// in the execute state; swap and sequential find add a second state (one read port,
// registered match vector). Sort runs odd-even phases down the chain; unique scans
// the held keys in turn; sorted find adds the sort when the flag is clear plus
// a binary search through the single read port. Reset clears count, ordered flag,
// reserve bit and the handshakes; keys are not cleared. A stalled result waits in
// its register and the engine holds until it goes.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_array_engine_unit_defines.svh"

module sorted_key_array_engine_unit #(
    parameter int DEPTH     = skae_pkg::SKAE_DEPTH,
    parameter int KEY_WIDTH = skae_pkg::SKAE_KEY_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  skae_pkg::cmd_item_t  cmd_item,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output skae_pkg::rsp_item_t  rsp_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);
    import skae_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ((CW > 5) ? CW : 5) + 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EXEC   = 8'b0000_0010,
        S_SWAP   = 8'b0000_0100,
        S_MATCH  = 8'b0000_1000,
        S_SORT   = 8'b0001_0000,
        S_SEARCH = 8'b0010_0000,
        S_UNIQ   = 8'b0100_0000,
        S_WAIT   = 8'b1000_0000
    } state_t;

    // Control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ordered_reg, ordered_next;
    logic            reserve_reg;
    logic [IW-1:0]   step_reg, step_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   hi_reg, hi_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // Payload
    cmd_item_t               cmd_reg;
    logic [KEY_WIDTH-1:0]    hold_reg, hold_next;
    logic [DEPTH-1:0]        match_reg, match_next;
    rsp_item_t               res_reg;
    rsp_item_t               rsp_reg;
    rsp_item_t               res_c;

    // Chain
    cell_ctl_t               ctl;
    logic [KEY_WIDTH-1:0]    data_a;
    logic [KEY_WIDTH-1:0]    data_b;
    logic [KEY_WIDTH-1:0]    key_in;
    logic [KEY_WIDTH-1:0]    key_q [DEPTH];
    logic [DEPTH-1:0]        eq_key;
    logic [DEPTH-1:0]        ge_key;
    logic [DEPTH-1:0]        le_key;
    logic [DEPTH-1:0]        eq_left;
    logic [DEPTH-1:0]        cnt_mask;

    // Decode helpers
    logic [WW-1:0]           pos_w, pos2_w, cnt_w;
    logic [IW-1:0]           pos_idx, pos2_idx, lo_sel, ptr_idx, mid_idx, rd_idx;
    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid_c;
    logic [KEY_WIDTH-1:0]    rd_key;
    logic                    pos_ok, pos2_ok, ins_bad, full, ins_fits;
    logic                    out_free, finish;
    logic [1:0]              r_status;
    logic                    r_found;
    logic [IW-1:0]           r_fidx;
    logic [KEY_WIDTH-1:0]    r_rval;

    assign key_in   = KEY_WIDTH'(cmd_reg.key_value);
    assign pos_w    = WW'(cmd_reg.position);
    assign pos2_w   = WW'(cmd_reg.other_position);
    assign cnt_w    = WW'(count_reg);
    assign pos_idx  = IW'(cmd_reg.position);
    assign pos2_idx = IW'(cmd_reg.other_position);
    assign lo_sel   = (pos_idx == '0) ? '0 : IW'(pos_idx - 1'b1);
    assign ptr_idx  = IW'(ptr_reg);
    assign pos_ok   = (pos_w < cnt_w);
    assign pos2_ok  = (pos2_w < cnt_w);
    assign ins_bad  = (pos_w > cnt_w);
    assign full     = (count_reg >= (CW'(DEPTH) - CW'(reserve_reg)));
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Insert keeps order when the new key sits between its neighbors
    assign ins_fits = ((cmd_reg.position == '0) || ge_key[lo_sel]) &&
                      ((pos_w == cnt_w) || le_key[pos_idx]);

    // Floor midpoint of [lo, hi)
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1;
    assign mid_c   = CW'(mid_sum >> 1);
    assign mid_idx = IW'(mid_c);

    // Held-slot mask
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            cnt_mask[i] = (CW'(i) < count_reg);
    end

    // Single read port into the chain
    assign rd_key = key_q[rd_idx];

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] left_k;
        logic [KEY_WIDTH-1:0] right_k;

        if (g == 0)
        begin : g_head
            assign left_k = '0;
        end
        else
        begin : g_link_l
            assign left_k = key_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign right_k = '0;
        end
        else
        begin : g_link_r
            assign right_k = key_q[g+1];
        end

        skae_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .INDEX     (g)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .data_a    (data_a),
            .data_b    (data_b),
            .cmp_key   (key_in),
            .left_key  (left_k),
            .right_key (right_k),
            .key_q     (key_q[g]),
            .eq_key    (eq_key[g]),
            .ge_key    (ge_key[g]),
            .le_key    (le_key[g]),
            .eq_left   (eq_left[g])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ordered_next = ordered_reg;
        hold_next    = hold_reg;
        match_next   = match_reg;
        step_next    = step_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        ptr_next     = ptr_reg;

        ctl.op     = CELL_HOLD;
        ctl.pos    = CTL_IDX_W'(pos_idx);
        ctl.a_idx  = CTL_IDX_W'(pos_idx);
        ctl.b_idx  = CTL_IDX_W'(pos2_idx);
        ctl.wr_a   = 1'b0;
        ctl.wr_b   = 1'b0;
        ctl.parity = step_reg[0];
        ctl.count  = CTL_CNT_W'(count_reg);
        data_a     = key_in;
        data_b     = hold_reg;
        rd_idx     = pos_idx;

        finish   = 1'b0;
        r_status = ST_OK;
        r_found  = 1'b0;
        r_fidx   = '0;
        r_rval   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_EXEC;
            end

            S_EXEC:
            begin
                unique case (cmd_reg.opcode)
                    OP_INSERT:
                    begin
                        finish = 1'b1;
                        if (ins_bad)
                            r_status = ST_RANGE;
                        else if (full)
                            r_status = ST_FULL;
                        else
                        begin
                            ctl.op     = CELL_SHR;
                            count_next = count_reg + 1'b1;
                            if ((count_reg != '0) && !ins_fits)
                                ordered_next = 1'b0;
                        end
                    end
                    OP_REMOVE:
                    begin
                        finish = 1'b1;
                        if (!pos_ok)
                            r_status = ST_RANGE;
                        else
                        begin
                            ctl.op     = CELL_SHL;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    OP_REPLACE:
                    begin
                        finish = 1'b1;
                        if (!pos_ok)
                            r_status = ST_RANGE;
                        else
                        begin
                            ctl.wr_a     = 1'b1;
                            ordered_next = 1'b0;
                        end
                    end
                    OP_SWAP:
                    begin
                        if (!pos_ok || !pos2_ok)
                        begin
                            finish   = 1'b1;
                            r_status = ST_RANGE;
                        end
                        else
                        begin
                            hold_next  = rd_key;
                            state_next = S_SWAP;
                        end
                    end
                    OP_FIND_SEQ:
                    begin
                        match_next = eq_key & cnt_mask;
                        state_next = S_MATCH;
                    end
                    OP_FIND_SORTED:
                    begin
                        step_next = '0;
                        lo_next   = '0;
                        hi_next   = count_reg;
                        state_next = ordered_reg ? S_SEARCH : S_SORT;
                    end
                    OP_SORT:
                    begin
                        step_next = '0;
                        if (ordered_reg)
                            finish = 1'b1;
                        else
                            state_next = S_SORT;
                    end
                    OP_UNIQ_ADJ:
                    begin
                        ptr_next   = CW'(1);
                        state_next = S_UNIQ;
                    end
                    OP_UNIQ_SORTED:
                    begin
                        step_next  = '0;
                        ptr_next   = CW'(1);
                        state_next = ordered_reg ? S_UNIQ : S_SORT;
                    end
                    OP_CLEAR:
                    begin
                        finish       = 1'b1;
                        count_next   = '0;
                        ordered_next = 1'b0;
                    end
                    OP_READ:
                    begin
                        finish = 1'b1;
                        if (!pos_ok)
                            r_status = ST_RANGE;
                        else
                            r_rval = rd_key;
                    end
                    default:
                    begin
                        // unused opcode: report state only
                        finish = 1'b1;
                    end
                endcase
            end

            S_SWAP:
            begin
                // second read fetches the other key; both slots written at once
                rd_idx       = pos2_idx;
                data_a       = rd_key;
                ctl.wr_a     = 1'b1;
                ctl.wr_b     = 1'b1;
                ordered_next = 1'b0;
                finish       = 1'b1;
            end

            S_MATCH:
            begin
                for (int i = DEPTH - 1; i >= 0; i--)
                begin
                    if (match_reg[i])
                        r_fidx = IW'(i);
                end
                r_found = |match_reg;
                finish  = 1'b1;
            end

            S_SORT:
            begin
                ctl.op    = CELL_SORT;
                step_next = step_reg + 1'b1;
                if (step_reg == IW'(DEPTH - 1))
                begin
                    step_next    = '0;
                    ordered_next = 1'b1;
                    if (cmd_reg.opcode == OP_FIND_SORTED)
                        state_next = S_SEARCH;
                    else if (cmd_reg.opcode == OP_UNIQ_SORTED)
                        state_next = S_UNIQ;
                    else
                        finish = 1'b1;
                end
            end

            S_SEARCH:
            begin
                rd_idx = mid_idx;
                if (lo_reg >= hi_reg)
                    finish = 1'b1;
                else if (rd_key == key_in)
                begin
                    finish  = 1'b1;
                    r_found = 1'b1;
                    r_fidx  = mid_idx;
                end
                else if (rd_key < key_in)
                    lo_next = mid_c + 1'b1;
                else
                    hi_next = mid_c;
            end

            S_UNIQ:
            begin
                if (ptr_reg >= count_reg)
                    finish = 1'b1;
                else if (eq_left[ptr_idx])
                begin
                    // drop the duplicate, stay at the same slot
                    ctl.op     = CELL_SHL;
                    ctl.pos    = CTL_IDX_W'(ptr_idx);
                    count_next = count_reg - 1'b1;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end

            S_WAIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
            state_next = out_free ? S_IDLE : S_WAIT;
    end

    // Result assembly
    always_comb
    begin
        res_c.status      = r_status;
        res_c.found       = r_found;
        res_c.found_index = 4'(r_fidx);
        res_c.read_value  = 32'(r_rval);
        res_c.count       = 5'(count_next);
        res_c.is_ordered  = ordered_next;
    end

    // Output register valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if ((finish || (state_reg == S_WAIT)) && out_free)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ordered_reg   <= 1'b0;
            reserve_reg   <= 1'b0;
            step_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ordered_reg   <= ordered_next;
            step_reg      <= step_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
                reserve_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hold_reg  <= hold_next;
        match_reg <= match_next;
        if ((state_reg == S_IDLE) && cmd_valid)
            cmd_reg <= cmd_item;
        if (finish && !out_free)
            res_reg <= res_c;
        if (finish && out_free)
            rsp_reg <= res_c;
        else if ((state_reg == S_WAIT) && out_free)
            rsp_reg <= res_reg;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;
    assign cfg_ready = 1'b1;

    // Checks
    `SKAE_ASSERT_NEXT(a_accept_exec, (state_reg == S_IDLE) && cmd_valid, state_reg == S_EXEC,
        "accepted item did not start execution")
    `SKAE_ASSERT_NOW(a_wait_has_rsp, state_reg == S_WAIT, rsp_valid_reg,
        "result parked while output register is empty")
    `SKAE_ASSERT_NEXT(a_sort_sets_flag, (state_reg == S_SORT) && (step_reg == IW'(DEPTH - 1)),
        ordered_reg, "ordered flag not set after last sort phase")
    `SKAE_ASSERT_NOW(a_search_window, state_reg == S_SEARCH, hi_reg <= count_reg,
        "search window runs past the held keys")
    `SKAE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH),
        "fill count above depth")

endmodule

`default_nettype wire
